// ===== design/bpc_pkg.sv =====
// Shared types and constants for the barometric compensation block.
// Used by bpc_pipe_ctl and baro_pressure_temperature_compensation; no dependencies.
package bpc_pkg;

    localparam int PipeDepth = 11;
    localparam int CfgIndexW = 3;
    localparam int CoeffW    = 16;
    localparam int RawW      = 24;
    localparam int TempW     = 15;
    localparam int PresW     = 17;

    // configuration register indexes
    localparam logic [CfgIndexW-1:0] RegPresSens   = 3'd0;
    localparam logic [CfgIndexW-1:0] RegPresOffset = 3'd1;
    localparam logic [CfgIndexW-1:0] RegSensTemp   = 3'd2;
    localparam logic [CfgIndexW-1:0] RegOffsetTemp = 3'd3;
    localparam logic [CfgIndexW-1:0] RegRefTemp    = 3'd4;
    localparam logic [CfgIndexW-1:0] RegTempSens   = 3'd5;

    localparam logic signed [19:0] TempRef      = 20'sd2000;
    localparam logic signed [19:0] TempVlowBias = 20'sd3500;
    localparam logic signed [20:0] TempLow      = -21'sd4000;
    localparam logic signed [20:0] TempHigh     = 21'sd8500;
    localparam logic signed [32:0] PresLow      = 33'sd1000;
    localparam logic signed [32:0] PresHigh     = 33'sd120000;

    typedef struct packed {
        logic [PipeDepth-1:0] ce;
        logic [PipeDepth-1:0] valid;
    } pipe_ctl_t;

endpackage

// ===== design/bpc_pipe_ctl.sv =====
// Valid and load-enable chain for the compensation pipeline.
// Depends on bpc_pkg (PipeDepth, pipe_ctl_t).
module bpc_pipe_ctl
    import bpc_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  logic      out_ready,
    output pipe_ctl_t ctl
);

    logic [PipeDepth-1:0] valid_reg;
    logic [PipeDepth-1:0] valid_next;
    logic [PipeDepth-1:0] ce;

    // a stage loads when it is empty or its successor loads
    always_comb begin
        ce[PipeDepth-1] = !valid_reg[PipeDepth-1] || out_ready;
        for (int i = PipeDepth - 2; i >= 0; i--) begin
            ce[i] = !valid_reg[i] || ce[i+1];
        end
    end

    always_comb begin
        valid_next[0] = ce[0] ? in_valid : valid_reg[0];
        for (int i = 1; i < PipeDepth; i++) begin
            valid_next[i] = ce[i] ? valid_reg[i-1] : valid_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign in_ready  = ce[0];
    assign ctl.ce    = ce;
    assign ctl.valid = valid_reg;

endmodule

// ===== design/baro_pressure_temperature_compensation.sv =====
// Top level of the barometric pressure and temperature compensation pipeline.
// Depends on bpc_pkg and bpc_pipe_ctl.
//
// Takes one raw pressure and one raw temperature word per cycle when not stalled
// and returns the compensated temperature (0.01 degC) and pressure (Pa), both
// saturated, with a flag when either was clamped. Second-order correction applies
// below 20.00 degC, with an extra term below -15.00 degC. The pipeline is 11
// register stages deep, and a new word is accepted every cycle unless a stalled
// output has filled it. Empty stages fill while the output waits.
// Write the six calibration registers only while the pipeline is empty.
module baro_pressure_temperature_compensation
    import bpc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [47:0]          s_tdata,   // pressure_raw[23:0], temperature_raw[47:24]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [31:0]          m_tdata,   // temperature_centideg[14:0], pressure_pa[31:15]
    output logic                 m_tuser,   // range_clamped[0]
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CfgIndexW-1:0] cfg_index,
    input  logic [CoeffW-1:0]    cfg_data
);

    pipe_ctl_t ctl;

    bpc_pipe_ctl u_ctl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .out_ready(m_tready),
        .ctl      (ctl)
    );

    assign m_tvalid  = ctl.valid[PipeDepth-1];
    assign cfg_ready = 1'b1;

    // calibration registers
    logic [CoeffW-1:0] c1_reg, c2_reg, c3_reg, c4_reg, c5_reg, c6_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c1_reg <= '0;
            c2_reg <= '0;
            c3_reg <= '0;
            c4_reg <= '0;
            c5_reg <= '0;
            c6_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                RegPresSens:   c1_reg <= cfg_data;
                RegPresOffset: c2_reg <= cfg_data;
                RegSensTemp:   c3_reg <= cfg_data;
                RegOffsetTemp: c4_reg <= cfg_data;
                RegRefTemp:    c5_reg <= cfg_data;
                RegTempSens:   c6_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // stage 1: dT
    logic [RawW-1:0]    d1_s1_reg;
    logic signed [24:0] dt_reg;

    always_ff @(posedge aclk) begin
        if (ctl.ce[0]) begin
            d1_s1_reg <= s_tdata[23:0];
            dt_reg    <= $signed({1'b0, s_tdata[47:24]}) - $signed({1'b0, c5_reg, 8'h00});
        end
    end

    // stage 2: products of dT
    logic [RawW-1:0]    d1_s2_reg;
    logic signed [41:0] dtc6_reg, c4dt_reg, c3dt_reg;
    logic signed [49:0] dtdt_reg;

    always_ff @(posedge aclk) begin
        if (ctl.ce[1]) begin
            d1_s2_reg <= d1_s1_reg;
            dtc6_reg  <= dt_reg * $signed({1'b0, c6_reg});
            c4dt_reg  <= dt_reg * $signed({1'b0, c4_reg});
            c3dt_reg  <= dt_reg * $signed({1'b0, c3_reg});
            dtdt_reg  <= dt_reg * dt_reg;
        end
    end

    // stage 3: first-order TEMP, OFF, SENS
    logic signed [18:0] dev_next;
    logic signed [19:0] devp_next;
    logic [RawW-1:0]    d1_s3_reg;
    logic signed [18:0] dev_reg;
    logic signed [19:0] devp_reg;
    logic signed [19:0] temp1_s3_reg;
    logic               low_s3_reg, vlow_s3_reg;
    logic signed [41:0] off1_s3_reg, sens1_s3_reg;
    logic [17:0]        t2_s3_reg;

    assign dev_next  = $signed(dtc6_reg[41:23]);
    assign devp_next = $signed({dev_next[18], dev_next}) + TempVlowBias;

    always_ff @(posedge aclk) begin
        if (ctl.ce[2]) begin
            d1_s3_reg    <= d1_s2_reg;
            dev_reg      <= dev_next;
            devp_reg     <= devp_next;
            temp1_s3_reg <= $signed({dev_next[18], dev_next}) + TempRef;
            low_s3_reg   <= dev_next[18];
            vlow_s3_reg  <= devp_next[19];
            off1_s3_reg  <= $signed({{7{c4dt_reg[41]}}, c4dt_reg[41:7]})
                          + $signed({10'b0, c2_reg, 16'h0000});
            sens1_s3_reg <= $signed({{8{c3dt_reg[41]}}, c3dt_reg[41:8]})
                          + $signed({11'b0, c1_reg, 15'h0000});
            t2_s3_reg    <= dtdt_reg[48:31];
        end
    end

    // stage 4: squares of the temperature deviations
    logic signed [37:0] q_full;
    logic signed [39:0] r_full;
    logic [RawW-1:0]    d1_s4_reg;
    logic [34:0]        q_reg, r_reg;
    logic signed [19:0] temp1_s4_reg;
    logic               low_s4_reg, vlow_s4_reg;
    logic signed [41:0] off1_s4_reg, sens1_s4_reg;
    logic [17:0]        t2_s4_reg;

    assign q_full = dev_reg * dev_reg;
    assign r_full = devp_reg * devp_reg;

    always_ff @(posedge aclk) begin
        if (ctl.ce[3]) begin
            d1_s4_reg    <= d1_s3_reg;
            q_reg        <= q_full[34:0];
            r_reg        <= r_full[34:0];
            temp1_s4_reg <= temp1_s3_reg;
            low_s4_reg   <= low_s3_reg;
            vlow_s4_reg  <= vlow_s3_reg;
            off1_s4_reg  <= off1_s3_reg;
            sens1_s4_reg <= sens1_s3_reg;
            t2_s4_reg    <= t2_s3_reg;
        end
    end

    // stage 5: second-order terms
    logic [37:0]        fiveq_next;
    logic [38:0]        sevenr_next, elevenr_next;
    logic [RawW-1:0]    d1_s5_reg;
    logic [36:0]        off2a_reg;
    logic [35:0]        sens2a_reg;
    logic [38:0]        off2b_reg;
    logic [37:0]        sens2b_reg;
    logic signed [19:0] temp1_s5_reg;
    logic               low_s5_reg;
    logic signed [41:0] off1_s5_reg, sens1_s5_reg;
    logic [17:0]        t2_s5_reg;

    assign fiveq_next   = {1'b0, q_reg, 2'b00} + {3'b000, q_reg};
    assign sevenr_next  = {1'b0, r_reg, 3'b000} - {4'b0000, r_reg};
    assign elevenr_next = {1'b0, r_reg, 3'b000} + {3'b000, r_reg, 1'b0} + {4'b0000, r_reg};

    always_ff @(posedge aclk) begin
        if (ctl.ce[4]) begin
            d1_s5_reg    <= d1_s4_reg;
            off2a_reg    <= fiveq_next[37:1];
            sens2a_reg   <= fiveq_next[37:2];
            off2b_reg    <= vlow_s4_reg ? sevenr_next : '0;
            sens2b_reg   <= vlow_s4_reg ? elevenr_next[38:1] : '0;
            temp1_s5_reg <= temp1_s4_reg;
            low_s5_reg   <= low_s4_reg;
            off1_s5_reg  <= off1_s4_reg;
            sens1_s5_reg <= sens1_s4_reg;
            t2_s5_reg    <= t2_s4_reg;
        end
    end

    // stage 6: OFF2, SENS2
    logic [RawW-1:0]    d1_s6_reg;
    logic [39:0]        off2_reg, sens2_reg;
    logic signed [19:0] temp1_s6_reg;
    logic               low_s6_reg;
    logic signed [41:0] off1_s6_reg, sens1_s6_reg;
    logic [17:0]        t2_s6_reg;

    always_ff @(posedge aclk) begin
        if (ctl.ce[5]) begin
            d1_s6_reg    <= d1_s5_reg;
            off2_reg     <= {3'b000, off2a_reg} + {1'b0, off2b_reg};
            sens2_reg    <= {4'h0, sens2a_reg} + {2'b00, sens2b_reg};
            temp1_s6_reg <= temp1_s5_reg;
            low_s6_reg   <= low_s5_reg;
            off1_s6_reg  <= off1_s5_reg;
            sens1_s6_reg <= sens1_s5_reg;
            t2_s6_reg    <= t2_s5_reg;
        end
    end

    // stage 7: apply the second-order correction
    logic [RawW-1:0]    d1_s7_reg;
    logic signed [41:0] off_s7_reg, sens_reg;
    logic signed [20:0] temp_s7_reg;

    always_ff @(posedge aclk) begin
        if (ctl.ce[6]) begin
            d1_s7_reg   <= d1_s6_reg;
            off_s7_reg  <= off1_s6_reg  - $signed(low_s6_reg ? {2'b00, off2_reg}  : 42'd0);
            sens_reg    <= sens1_s6_reg - $signed(low_s6_reg ? {2'b00, sens2_reg} : 42'd0);
            temp_s7_reg <= $signed({temp1_s6_reg[19], temp1_s6_reg})
                         - $signed(low_s6_reg ? {3'b000, t2_s6_reg} : 21'd0);
        end
    end

    // stage 8: D1*SENS as two partial products, clamp temperature
    logic signed [45:0] pp_hi_reg;
    logic [44:0]        pp_lo_reg;
    logic signed [41:0] off_s8_reg;
    logic [TempW-1:0]   tc_s8_reg;
    logic               tclamp_s8_reg;
    logic signed [20:0] tc_next;
    logic               tclamp_next;

    always_comb begin
        tc_next     = temp_s7_reg;
        tclamp_next = 1'b0;
        if (temp_s7_reg < TempLow) begin
            tc_next     = TempLow;
            tclamp_next = 1'b1;
        end else if (temp_s7_reg > TempHigh) begin
            tc_next     = TempHigh;
            tclamp_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.ce[7]) begin
            pp_lo_reg     <= d1_s7_reg * sens_reg[20:0];
            pp_hi_reg     <= $signed({1'b0, d1_s7_reg}) * $signed(sens_reg[41:21]);
            off_s8_reg    <= off_s7_reg;
            tc_s8_reg     <= tc_next[TempW-1:0];
            tclamp_s8_reg <= tclamp_next;
        end
    end

    // stage 9: D1*SENS >> 21
    logic signed [46:0] ps_reg;
    logic signed [41:0] off_s9_reg;
    logic [TempW-1:0]   tc_s9_reg;
    logic               tclamp_s9_reg;

    always_ff @(posedge aclk) begin
        if (ctl.ce[8]) begin
            ps_reg        <= $signed({pp_hi_reg[45], pp_hi_reg})
                           + $signed({23'b0, pp_lo_reg[44:21]});
            off_s9_reg    <= off_s8_reg;
            tc_s9_reg     <= tc_s8_reg;
            tclamp_s9_reg <= tclamp_s8_reg;
        end
    end

    // stage 10: subtract OFF
    logic signed [47:0] x_reg;
    logic [TempW-1:0]   tc_s10_reg;
    logic               tclamp_s10_reg;

    always_ff @(posedge aclk) begin
        if (ctl.ce[9]) begin
            x_reg          <= $signed({ps_reg[46], ps_reg})
                            - $signed({{6{off_s9_reg[41]}}, off_s9_reg});
            tc_s10_reg     <= tc_s9_reg;
            tclamp_s10_reg <= tclamp_s9_reg;
        end
    end

    // stage 11: pressure >> 15, clamp, output word
    logic signed [32:0] p_next, pc_next;
    logic               pclamp_next;
    logic [TempW-1:0]   temp_out_reg;
    logic [PresW-1:0]   pres_out_reg;
    logic               clamp_out_reg;

    assign p_next = $signed(x_reg[47:15]);

    always_comb begin
        pc_next     = p_next;
        pclamp_next = 1'b0;
        if (p_next < PresLow) begin
            pc_next     = PresLow;
            pclamp_next = 1'b1;
        end else if (p_next > PresHigh) begin
            pc_next     = PresHigh;
            pclamp_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.ce[10]) begin
            temp_out_reg  <= tc_s10_reg;
            pres_out_reg  <= pc_next[PresW-1:0];
            clamp_out_reg <= tclamp_s10_reg | pclamp_next;
        end
    end

    assign m_tdata = {pres_out_reg, temp_out_reg};
    assign m_tuser = clamp_out_reg;

endmodule

// ===== tb/tb_baro_pressure_temperature_compensation.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for baro_pressure_temperature_compensation: streams raw
// pressure/temperature words under random handshake idling and compares every result
// against a behavioral compensation model. Depends on bpc_pkg and the block's RTL.
module tb_baro_pressure_temperature_compensation
    import bpc_pkg::*;
();

    localparam int     StallLimit    = 4000;
    localparam int     ItemsPerPhase = 134;
    localparam longint TempPivot     = 2000;
    localparam longint TempVeryCold  = -1500;
    localparam longint VeryColdBias  = 1500;

    localparam logic [CfgIndexW-1:0] RegUnusedLo = 3'd6;
    localparam logic [CfgIndexW-1:0] RegUnusedHi = 3'd7;

    typedef enum int {CalNominal, CalRandom, CalAllOnes, CalAllZero} cal_kind_t;

    typedef struct packed {
        logic signed [TempW-1:0] temp_c;
        logic [PresW-1:0]        pres_pa;
        logic                    clamped;
    } reading_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [47:0]          s_tdata;   // pressure_raw[23:0], temperature_raw[47:24]
    logic                 m_tvalid;
    logic                 m_tready;
    logic [31:0]          m_tdata;   // temperature_centideg[14:0], pressure_pa[31:15]
    logic                 m_tuser;   // range_clamped[0]
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CfgIndexW-1:0] cfg_index;
    logic [CoeffW-1:0]    cfg_data;

    logic [CoeffW-1:0] c_pres_sens, c_pres_off, c_sens_tc, c_off_tc, c_ref_temp, c_temp_sens;

    reading_t pending_readings[$];
    int       errors;
    int       idle_cycles;
    int       burst_left;
    bit       idle_en;

    baro_pressure_temperature_compensation dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic reading_t compensate(input logic [RawW-1:0] d1_raw,
                                            input logic [RawW-1:0] d2_raw);
        longint   d1, d2, dt, temp, off, sens, p, t2, q, off2, sens2, r;
        reading_t rd;
        d1   = longint'(d1_raw);
        d2   = longint'(d2_raw);
        dt   = d2 - (longint'(c_ref_temp) <<< 8);
        temp = TempPivot + ((dt * longint'(c_temp_sens)) >>> 23);
        off  = (longint'(c_pres_off) <<< 16) + ((longint'(c_off_tc) * dt) >>> 7);
        sens = (longint'(c_pres_sens) <<< 15) + ((longint'(c_sens_tc) * dt) >>> 8);
        if (temp < TempPivot) begin
            t2    = (dt * dt) >>> 31;
            q     = (temp - TempPivot) * (temp - TempPivot);
            off2  = (5 * q) >>> 1;
            sens2 = (5 * q) >>> 2;
            if (temp < TempVeryCold) begin
                r     = (temp + VeryColdBias) * (temp + VeryColdBias);
                off2  = off2 + 7 * r;
                sens2 = sens2 + ((11 * r) >>> 1);
            end
            off  = off - off2;
            sens = sens - sens2;
            temp = temp - t2;
        end
        p = (((d1 * sens) >>> 21) - off) >>> 15;
        rd.clamped = 1'b0;
        if (temp < longint'(TempLow)) begin
            temp = longint'(TempLow);
            rd.clamped = 1'b1;
        end
        if (temp > longint'(TempHigh)) begin
            temp = longint'(TempHigh);
            rd.clamped = 1'b1;
        end
        if (p < longint'(PresLow)) begin
            p = longint'(PresLow);
            rd.clamped = 1'b1;
        end
        if (p > longint'(PresHigh)) begin
            p = longint'(PresHigh);
            rd.clamped = 1'b1;
        end
        rd.temp_c  = temp[TempW-1:0];
        rd.pres_pa = p[PresW-1:0];
        return rd;
    endfunction

    task automatic report_mismatch(input string what, input reading_t want, input reading_t got);
        errors++;
        if (errors <= 10)
            $display("%0t mismatch %s: expected temp=%0d pres=%0d clamp=%0b,",
                     $realtime, what, want.temp_c, want.pres_pa, want.clamped,
                     " got temp=%0d pres=%0d clamp=%0b",
                     got.temp_c, got.pres_pa, got.clamped);
    endtask

    // check each result word against the oldest expectation
    always @(posedge aclk) begin
        reading_t want, got;
        if (aresetn && m_tvalid && m_tready) begin
            got.temp_c  = m_tdata[14:0];
            got.pres_pa = m_tdata[31:15];
            got.clamped = m_tuser;
            if (pending_readings.size() == 0) begin
                report_mismatch("unexpected word", '0, got);
            end else begin
                want = pending_readings.pop_front();
                if (got.temp_c != want.temp_c)
                    report_mismatch("temperature", want, got);
                if (got.pres_pa != want.pres_pa)
                    report_mismatch("pressure", want, got);
                if (got.clamped != want.clamped)
                    report_mismatch("clamp flag", want, got);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > StallLimit) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // receiver stall pattern: free-running, random, or long stalls; mode changes at random intervals
    initial begin
        int rx_mode, mode_left, stall_left;
        m_tready   = 1'b0;
        rx_mode    = 0;
        mode_left  = 0;
        stall_left = 0;
        forever begin
            @(negedge aclk);
            if (mode_left == 0) begin
                rx_mode   = $urandom_range(0, 2);
                mode_left = $urandom_range(20, 120);
            end
            mode_left--;
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else if (rx_mode == 1) begin
                m_tready <= ($urandom_range(0, 3) != 0);
            end else if (rx_mode == 2 && $urandom_range(0, 15) == 0) begin
                m_tready   <= 1'b0;
                stall_left = $urandom_range(1, 30);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic send_sample(input logic [RawW-1:0] d1, input logic [RawW-1:0] d2);
        int gap;
        gap = 0;
        if (idle_en) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                gap        = $urandom_range(1, 8);
            end
            burst_left--;
        end
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {d2, d1};
        do @(posedge aclk); while (!s_tready);
        pending_readings.push_back(compensate(d1, d2));
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_readings.size() != 0) @(posedge aclk);
    endtask

    task automatic write_coeff(input logic [CfgIndexW-1:0] idx, input logic [CoeffW-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            RegPresSens:   c_pres_sens = val;
            RegPresOffset: c_pres_off  = val;
            RegSensTemp:   c_sens_tc   = val;
            RegOffsetTemp: c_off_tc    = val;
            RegRefTemp:    c_ref_temp  = val;
            RegTempSens:   c_temp_sens = val;
            default: ;
        endcase
    endtask

    task automatic load_calibration(input logic [CoeffW-1:0] w0, input logic [CoeffW-1:0] w1,
                                    input logic [CoeffW-1:0] w2, input logic [CoeffW-1:0] w3,
                                    input logic [CoeffW-1:0] w4, input logic [CoeffW-1:0] w5);
        wait_drained();
        write_coeff(RegPresSens, w0);
        write_coeff(RegPresOffset, w1);
        write_coeff(RegSensTemp, w2);
        write_coeff(RegOffsetTemp, w3);
        write_coeff(RegRefTemp, w4);
        write_coeff(RegTempSens, w5);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_reset_values();
        send_sample(24'd9085466, 24'd8569150);
        send_sample(24'hFFFFFF, 24'hFFFFFF);
    endtask

    task automatic test_nominal_cases();
        load_calibration(16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312);
        send_sample(24'd9085466, 24'd8569150);  // warm, first order only
        send_sample(24'd9085466, 24'd7900000);  // below 20 degrees
        send_sample(24'd9085466, 24'd7300000);  // below -15 degrees
        send_sample(24'd9085466, 24'd0);        // temperature clamps low
        send_sample(24'd9085466, 24'hFFFFFF);   // temperature clamps high
        send_sample(24'd0, 24'd8569150);        // negative pressure clamps low
        send_sample(24'hFFFFFF, 24'd8569150);   // pressure clamps high
        send_sample(24'd1, 24'd8566784);        // zero temperature offset
    endtask

    task automatic test_coeff_extremes();
        load_calibration(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_sample(24'hFFFFFF, 24'hFFFFFF);
        send_sample(24'd0, 24'd0);
        load_calibration(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_sample(24'hFFFFFF, 24'hFFFFFF);
        send_sample(24'd0, 24'd0);
        send_sample(24'hFFFFFF, 24'd0);
        send_sample(24'h800000, 24'hFFFF00);
    endtask

    task automatic test_unused_index();
        load_calibration(16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312);
        write_coeff(RegUnusedLo, 16'hFFFF);
        write_coeff(RegUnusedHi, 16'h0000);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        send_sample(24'd9085466, 24'd8569150);
        send_sample(24'd8000000, 24'd7700000);
    endtask

    function automatic logic [CoeffW-1:0] pick_word(input cal_kind_t kind, input int lo,
                                                     input int hi);
        case (kind)
            CalNominal: return CoeffW'($urandom_range(lo, hi));
            CalRandom:  return CoeffW'($urandom);
            CalAllOnes: return '1;
            default:    return '0;
        endcase
    endfunction

    task automatic run_random_phase(input cal_kind_t kind, input bit with_idle);
        logic [RawW-1:0] d1, d2;
        int              offs;
        idle_en = with_idle;
        load_calibration(pick_word(kind, 30000, 50000), pick_word(kind, 30000, 45000),
                         pick_word(kind, 18000, 28000), pick_word(kind, 18000, 28000),
                         pick_word(kind, 28000, 36000), pick_word(kind, 20000, 32000));
        for (int i = 0; i < ItemsPerPhase; i++) begin
            d1 = RawW'($urandom);
            if ($urandom_range(0, 3) == 0) begin
                d2 = RawW'($urandom);
            end else begin
                offs = int'($urandom_range(0, 1 << 23)) - (1 << 22);
                d2   = RawW'((int'(c_ref_temp) <<< 8) + offs);
            end
            send_sample(d1, d2);
        end
    endtask

    task automatic test_random_calibrations();
        run_random_phase(CalNominal, 1'b1);
        run_random_phase(CalRandom, 1'b1);
        run_random_phase(CalRandom, 1'b0);
        run_random_phase(CalAllOnes, 1'b1);
        run_random_phase(CalNominal, 1'b0);
        run_random_phase(CalAllZero, 1'b1);
    endtask

    initial begin
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        c_pres_sens = '0;
        c_pres_off  = '0;
        c_sens_tc   = '0;
        c_off_tc    = '0;
        c_ref_temp  = '0;
        c_temp_sens = '0;
        errors      = 0;
        idle_cycles = 0;
        burst_left  = 0;
        idle_en     = 1'b1;
        repeat (12) @(negedge aclk);
        aresetn = 1'b1;

        test_reset_values();
        test_nominal_cases();
        test_coeff_extremes();
        test_unused_index();
        test_random_calibrations();

        wait_drained();
        repeat (PipeDepth + 4) @(posedge aclk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== baro_pressure_temperature_compensation.f =====
design/bpc_pkg.sv
design/bpc_pipe_ctl.sv
design/baro_pressure_temperature_compensation.sv
tb/tb_baro_pressure_temperature_compensation.sv
